@@ rtl/hci_h4_pkg.sv @@
// ----------------------------------------------------------------------------
// HCI H4 deframer package
// Packet type codes, packet kind codes and the framing state type.
// ----------------------------------------------------------------------------
package hci_h4_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned HDR_CNT_W = 3;
    localparam int unsigned LEN_W     = 16;

    // H4 packet type bytes
    localparam logic [BYTE_W-1:0] H4_TYPE_CMD = 8'd1;
    localparam logic [BYTE_W-1:0] H4_TYPE_ACL = 8'd2;
    localparam logic [BYTE_W-1:0] H4_TYPE_SCO = 8'd3;
    localparam logic [BYTE_W-1:0] H4_TYPE_EVT = 8'd4;

    // header bytes following the type byte
    localparam logic [HDR_CNT_W-1:0] ACL_HDR_LEN = 3'd4;
    localparam logic [HDR_CNT_W-1:0] EVT_HDR_LEN = 3'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACL = 3'd0,
        KIND_EVT = 3'd1,
        KIND_SCO = 3'd2,
        KIND_CMD = 3'd3,
        KIND_ERR = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HDR  = 2'd1,
        PH_PAY  = 2'd2
    } t_phase;

endpackage

@@ rtl/hci_h4_if.sv @@
// ----------------------------------------------------------------------------
// HCI H4 deframer channels
// Valid/ready request channels for received bytes and tagged bytes.
// ----------------------------------------------------------------------------
interface hci_h4_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hci_h4_tag_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] packet_kind;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       in_header;

    modport source (output valid, output out_byte, output packet_kind,
                    output first_of_packet, output last_of_packet,
                    output in_header, input ready);
    modport sink   (input valid, input out_byte, input packet_kind,
                    input first_of_packet, input last_of_packet,
                    input in_header, output ready);
endinterface

@@ rtl/hci_h4_packet_deframer_unit.sv @@
// An accepted byte's tagged result is registered and presented in the next cycle.
// Throughput: one byte per cycle while the sink takes results; the framing
// counters update in the accept cycle. A result waiting in the output register
// does not block the next byte if the sink takes it in the same cycle.
// Reset (synchronous, active low): idle awaiting a type byte, counters cleared,
// output register empty.
// ----------------------------------------------------------------------------
// HCI H4 packet deframer
// Tags each received byte with packet kind, first/last and header flags.
// ----------------------------------------------------------------------------
module hci_h4_packet_deframer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hci_h4_byte_if.sink         i_in,
    hci_h4_tag_if.source        o_out
);
    import hci_h4_pkg::*;

    t_phase               r_phase,  n_phase;
    logic [HDR_CNT_W-1:0] r_hdr_left, n_hdr_left;
    t_kind                r_kind,   n_kind;
    logic [BYTE_W-1:0]    r_len_lo, n_len_lo;
    logic [LEN_W-1:0]     r_pay_left, n_pay_left;

    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_byte;
    t_kind                r_out_kind;
    logic                 r_out_first;
    logic                 r_out_last;
    logic                 r_out_hdr;

    logic                 w_accept;
    logic [BYTE_W-1:0]    w_byte;
    logic [LEN_W-1:0]     w_hdr_len;
    logic [LEN_W-1:0]     w_pay_dec;
    logic                 w_hdr_end;
    t_kind                w_start_kind;
    logic                 w_start_last;
    t_kind                w_kind;
    logic                 w_first;
    logic                 w_last;
    logic                 w_hdr;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_byte     = i_in.data_byte;

    assign w_hdr_end = (r_hdr_left <= HDR_CNT_W'(1));
    assign w_hdr_len = (r_kind == KIND_ACL) ? {w_byte, r_len_lo}
                                            : {{(LEN_W-BYTE_W){1'b0}}, w_byte};
    assign w_pay_dec = r_pay_left - LEN_W'(1);

    always_comb begin
        unique case (w_byte)
            H4_TYPE_ACL: begin w_start_kind = KIND_ACL; w_start_last = 1'b0; end
            H4_TYPE_EVT: begin w_start_kind = KIND_EVT; w_start_last = 1'b0; end
            H4_TYPE_SCO: begin w_start_kind = KIND_SCO; w_start_last = 1'b1; end
            H4_TYPE_CMD: begin w_start_kind = KIND_CMD; w_start_last = 1'b1; end
            default:     begin w_start_kind = KIND_ERR; w_start_last = 1'b1; end
        endcase
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_hdr_left = r_hdr_left;
        n_kind     = r_kind;
        n_len_lo   = r_len_lo;
        n_pay_left = r_pay_left;
        unique case (r_phase)
            PH_HDR: begin
                if (r_kind == KIND_ACL && r_hdr_left == HDR_CNT_W'(2)) begin
                    n_len_lo = w_byte;
                end
                if (w_hdr_end) begin
                    n_pay_left = w_hdr_len;
                    n_hdr_left = '0;
                    n_phase    = (w_hdr_len == '0) ? PH_IDLE : PH_PAY;
                end else begin
                    n_hdr_left = r_hdr_left - HDR_CNT_W'(1);
                end
            end
            PH_PAY: begin
                n_pay_left = w_pay_dec;
                if (w_pay_dec == '0) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_kind  = w_start_kind;
                n_phase = w_start_last ? PH_IDLE : PH_HDR;
                if (w_start_kind == KIND_ACL) begin
                    n_hdr_left = ACL_HDR_LEN;
                end else if (w_start_kind == KIND_EVT) begin
                    n_hdr_left = EVT_HDR_LEN;
                end
            end
        endcase
    end

    // result fields
    always_comb begin
        unique case (r_phase)
            PH_HDR: begin
                w_kind  = r_kind;
                w_first = 1'b0;
                w_last  = w_hdr_end && (w_hdr_len == '0);
                w_hdr   = 1'b1;
            end
            PH_PAY: begin
                w_kind  = r_kind;
                w_first = 1'b0;
                w_last  = (w_pay_dec == '0);
                w_hdr   = 1'b0;
            end
            default: begin
                w_kind  = w_start_kind;
                w_first = 1'b1;
                w_last  = w_start_last;
                w_hdr   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hdr_left  <= '0;
            r_kind      <= KIND_ACL;
            r_len_lo    <= '0;
            r_pay_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase    <= n_phase;
                r_hdr_left <= n_hdr_left;
                r_kind     <= n_kind;
                r_len_lo   <= n_len_lo;
                r_pay_left <= n_pay_left;
            end
            if (i_in.ready) begin
                r_out_valid <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_byte  <= w_byte;
            r_out_kind  <= w_kind;
            r_out_first <= w_first;
            r_out_last  <= w_last;
            r_out_hdr   <= w_hdr;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.out_byte        = r_out_byte;
    assign o_out.packet_kind     = r_out_kind;
    assign o_out.first_of_packet = r_out_first;
    assign o_out.last_of_packet  = r_out_last;
    assign o_out.in_header       = r_out_hdr;

endmodule
